// ===== rtl/core/sle_pkg.sv =====
// shared types and codes for the sorted list engine
package sle_pkg;

	localparam int VALUE_W = 32;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// operation broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [VALUE_W-1:0] value;
	} sle_op_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic               valid;
		logic               ge;
		logic [VALUE_W-1:0] data;
	} sle_link_t;

endpackage

// ===== rtl/core/sorted_list_engine.sv =====
// sorted list engine top level: command register, cell chain and result register
// latency: a result strobes on done once the start beat passes the command register and the result register
// throughput: one command per cycle; the cell chain compares combinationally and shifts its registers on that command
// busy stays low, the list update of one command lands before the next compares
// reset: arst_n empties the list and drops any command in flight, entries are not cleared
// the receiver cannot stall, each result beat is shown for one cycle
module sorted_list_engine #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [sle_pkg::CMD_W-1:0]           cmd,
	input  logic signed [sle_pkg::VALUE_W-1:0]  value,
	output logic                                done,
	output logic [sle_pkg::STATUS_W-1:0]        status,
	output logic [sle_pkg::POS_W-1:0]           position
);

	localparam int PW = sle_pkg::POS_W;

	logic                        vld_s1;
	logic [sle_pkg::CMD_W-1:0]   cmd_s1;
	logic [sle_pkg::VALUE_W-1:0] value_s1;

	sle_pkg::sle_op_t   op;
	sle_pkg::sle_link_t link_w [DEPTH];
	logic [DEPTH-1:0]   hit_vec;
	logic [DEPTH-1:0]   valid_vec;
	logic               full;
	logic               found;
	logic [PW-1:0]      pos_hit;

	logic                         done_q;
	logic [sle_pkg::STATUS_W-1:0] status_q;
	logic [PW-1:0]                position_q;
	logic [sle_pkg::STATUS_W-1:0] status_d;
	logic [PW-1:0]                position_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
			value_s1 <= value;
		end
	end

	assign full = valid_vec[DEPTH-1];
	assign found = |hit_vec;

	assign op.ins = vld_s1 && (cmd_s1 == sle_pkg::CMD_INSERT) && !full;
	assign op.del = vld_s1 && (cmd_s1 == sle_pkg::CMD_DELETE) && found;
	assign op.value = value_s1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sle_pkg::sle_link_t left_l;
		sle_pkg::sle_link_t right_l;

		if (g == 0) begin : g_head
			assign left_l = '{valid: 1'b1, ge: 1'b0, data: '0};
		end else begin : g_mid
			assign left_l = link_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_l = '{valid: 1'b0, ge: 1'b0, data: '0};
		end else begin : g_next
			assign right_l = link_w[g+1];
		end

		sle_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (left_l),
			.right  (right_l),
			.link   (link_w[g]),
			.hit    (hit_vec[g])
		);

		assign valid_vec[g] = link_w[g].valid;
	end

	// one-hot hit to 1-based position, low bits kept
	always_comb begin
		pos_hit = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit_vec[i]) begin
				pos_hit = pos_hit | PW'(i + 1);
			end
		end
	end

	always_comb begin
		status_d = sle_pkg::STATUS_OK;
		position_d = '0;
		unique case (cmd_s1)
			sle_pkg::CMD_INSERT: begin
				if (full) begin
					status_d = sle_pkg::STATUS_FULL;
				end
			end
			sle_pkg::CMD_DELETE: begin
				if (!found) begin
					status_d = sle_pkg::STATUS_MISS;
				end
			end
			sle_pkg::CMD_SEARCH: begin
				if (found) begin
					position_d = pos_hit;
				end else begin
					status_d = sle_pkg::STATUS_MISS;
				end
			end
			default: begin
				status_d = sle_pkg::STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_q <= status_d;
			position_q <= position_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign position = position_q;

	// at most one cell claims the first match
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell claims the first match");

	// occupied cells stay packed from the head of the chain
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + DEPTH'(1)) & valid_vec) == '0)
		else $error("occupied cells are not contiguous");

	// every command beat gives one result beat
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("command without result beat");

	// insert grows the list by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("insert did not add one entry");

	// delete shrinks the list by one
	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		op.del |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
		else $error("delete did not remove one entry");

endmodule

// ===== rtl/core/sle_cell.sv =====
// one list slot: holds an entry, compares it and shifts with its neighbors
module sle_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sle_pkg::sle_op_t   op,
	input  sle_pkg::sle_link_t left,
	input  sle_pkg::sle_link_t right,
	output sle_pkg::sle_link_t link,
	output logic               hit
);

	logic                        valid_q;
	logic [sle_pkg::VALUE_W-1:0] data_q;
	logic                        ge;
	logic                        eq;

	assign ge = valid_q && ($signed(data_q) >= $signed(op.value));
	assign eq = valid_q && (data_q == op.value);
	// first entry not below the value, and equal to it
	assign hit = eq && !left.ge;

	assign link.valid = valid_q;
	assign link.ge = ge;
	assign link.data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.ins) begin
			if (left.ge || ge || (!valid_q && left.valid)) begin
				valid_q <= 1'b1;
			end
		end else if (op.del && ge) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (left.ge) begin
				data_q <= left.data;
			end else if (ge || (!valid_q && left.valid)) begin
				data_q <= op.value;
			end
		end else if (op.del && ge) begin
			data_q <= right.data;
		end
	end

endmodule

// ===== verif/sorted_list_engine_tb.sv =====
`timescale 1ns / 100ps
// testbench for sorted_list_engine: directed script and random commands checked against a list predictor
module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_ROWS = 20;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} list_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]    op;
		logic [VALUE_W-1:0]  operand;
		logic [4:0]          reps;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} stim_row_t;

	// typed rows carry their own expectation, the rest go through the predictor
	localparam stim_row_t SCRIPT [NUM_ROWS] = '{
		'{CMD_SEARCH, 32'h00000000, 5'd1, 1'b1, STATUS_MISS, 5'd0},
		'{CMD_DELETE, 32'h00000000, 5'd1, 1'b1, STATUS_MISS, 5'd0},
		'{CMD_UNUSED, 32'h00000005, 5'd1, 1'b1, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'h7fffffff, 5'd1, 1'b1, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'h80000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'h00000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'hffffffff, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'h00000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_SEARCH, 32'h80000000, 5'd1, 1'b1, STATUS_OK, 5'd1},
		'{CMD_SEARCH, 32'h7fffffff, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_SEARCH, 32'h00000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_DELETE, 32'h00000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_SEARCH, 32'h00000000, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'h55555555, 5'd12, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'haaaaaaaa, 5'd1, 1'b1, STATUS_FULL, 5'd0},
		'{CMD_SEARCH, 32'h55555555, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_DELETE, 32'h7fffffff, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_INSERT, 32'haaaaaaaa, 5'd1, 1'b0, STATUS_OK, 5'd0},
		'{CMD_UNUSED, 32'hffffffff, 5'd1, 1'b1, STATUS_OK, 5'd0},
		'{CMD_DELETE, 32'h12345678, 5'd1, 1'b1, STATUS_MISS, 5'd0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [CMD_W-1:0]           cmd = CMD_INSERT;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       busy;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic [POS_W-1:0]           position;

	logic signed [VALUE_W-1:0]  shelf [LIST_DEPTH];
	logic [POS_W-1:0]           fill = '0;
	list_result_t               pending_results [$];
	int                         fault_count = 0;
	int                         cycle_count = 0;
	int                         idle_pct = 11;

	sorted_list_engine #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.done(done),
		.status(status),
		.position(position)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_list_engine_tb: FAIL");
			$finish;
		end
	end

	function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] op,
			input logic signed [VALUE_W-1:0] v);
		list_result_t r;
		int n;
		int slot;
		int hit;
		r.status = STATUS_OK;
		r.position = '0;
		n = int'(fill);
		hit = 0;
		while (hit < n && shelf[hit] != v)
			hit++;
		case (op)
			CMD_INSERT: begin
				if (n >= LIST_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					slot = 0;
					while (slot < n && shelf[slot] < v)
						slot++;
					for (int i = n; i > slot; i--)
						shelf[i] = shelf[i-1];
					shelf[slot] = v;
					fill = fill + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (hit >= n) begin
					r.status = STATUS_MISS;
				end else begin
					for (int i = hit; i < n - 1; i++)
						shelf[i] = shelf[i+1];
					fill = fill - 1'b1;
				end
			end
			CMD_SEARCH: begin
				if (hit >= n)
					r.status = STATUS_MISS;
				else
					r.position = POS_W'(hit + 1);
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly stored values, extremes and near-zero collisions, some fresh random words
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && fill != 0)
			return shelf[$urandom_range(int'(fill) - 1)];
		if (roll < 70) begin
			case ($urandom_range(5))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				default: return $signed(VALUE_W'($urandom_range(6))) - 3;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_beat(input logic [CMD_W-1:0] op, input logic signed [VALUE_W-1:0] v,
			input logic typed, input list_result_t fixed);
		list_result_t predicted;
		start <= 1'b1;
		cmd <= op;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = apply_list_cmd(op, v);
		pending_results.push_back(typed ? fixed : predicted);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= CMD_W'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status %0d position %0d", status, position);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fault_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					fault_count++;
				end
			end
		end
	end

	initial begin
		logic filling;
		logic [CMD_W-1:0] op;
		int roll;
		filling = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++)
			for (int k = 0; k < int'(SCRIPT[r].reps); k++)
				send_beat(SCRIPT[r].op, SCRIPT[r].operand, SCRIPT[r].typed,
					'{SCRIPT[r].status, SCRIPT[r].position});

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3)
				idle_pct = 57;
			else if (k == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			// swing between filling and draining so full and empty both recur
			if (k % 48 == 0)
				filling = ~filling;
			roll = $urandom_range(99);
			if (roll < 3)
				op = CMD_UNUSED;
			else if (roll < 25)
				op = CMD_SEARCH;
			else if (roll < (filling ? 80 : 45))
				op = CMD_INSERT;
			else
				op = CMD_DELETE;
			send_beat(op, pick_value(), 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("sorted_list_engine_tb: PASS");
		else
			$display("sorted_list_engine_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sorted_list_engine.sv
verif/sorted_list_engine_tb.sv
